// ===== rtl/tournament_branch_predictor_unit_assert.svh =====
// Assertion macros shared by the tournament branch predictor RTL.
`ifndef TOURNAMENT_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked at each rising edge, switched off while reset is asserted.
`define TBPU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("tournament predictor assertion failed");
// Checked at each rising edge, reset included.
`define TBPU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("tournament predictor assertion failed");
`else
`define TBPU_ASSERT(lbl, clk, rstn, prop)
`define TBPU_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== rtl/tbpu_pkg.sv =====
// Types, constants and counter helper for the tournament branch predictor.
package tbpu_pkg;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_WEAK_TAKEN   = 2'd2;
  localparam ctr_t CTR_WEAK_NOT_TKN = 2'd1;
  localparam ctr_t CTR_MAX          = 2'd3;
  localparam ctr_t CTR_MIN          = 2'd0;

  localparam int unsigned PC_W         = 24;
  localparam int unsigned IN_TDATA_W   = 32;
  localparam int unsigned OUT_TDATA_W  = 8;
  localparam int unsigned TAKEN_BIT    = 24;
  localparam int unsigned PRED_BIT     = 0;
  localparam int unsigned MISPRED_BIT  = 1;

  // Moves a 2-bit saturating counter one step toward the outcome.
  function automatic ctr_t train_ctr(input ctr_t c, input logic t);
    ctr_t r;
    r = c;
    if (t) begin
      if (c != CTR_MAX) r = c + 2'd1;
    end else begin
      if (c != CTR_MIN) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/tournament_branch_predictor_unit.sv =====
// Tournament branch predictor: bimodal and gshare tables with a per-address chooser.
//
// One branch (address and actual outcome) enters per beat and one result beat
// leaves for it: the selected prediction, which predictor made it, and whether
// it was wrong. The block takes a new branch every cycle unless the clearing
// pass runs or a result held in the output register waits on out_tready, which
// stalls the second stage and then the input side. The three counter tables sit
// in synchronous memories with registered reads; the second pipeline stage
// computes the prediction, trains the counters and writes them back, and a
// one-entry bypass per table forwards the last write into that table when a
// later branch reads the same entry. After reset the block runs a clearing pass
// over 2**max(GSHARE_INDEX_BITS, BIMODAL_INDEX_BITS, CHOOSER_INDEX_BITS) entries
// (1024 with the default sizes), writing the reset counter values into every
// entry; in_tready stays low until it is done.
module tournament_branch_predictor_unit
  import tbpu_pkg::*;
#(
  parameter int unsigned GSHARE_INDEX_BITS  = 10,
  parameter int unsigned HISTORY_BITS       = 8,
  parameter int unsigned BIMODAL_INDEX_BITS = 5,
  parameter int unsigned CHOOSER_INDEX_BITS = 5
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [23:0] pc, [24] taken, rest zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [0] predicted_taken, [1] mispredicted
  output logic                   out_tuser   // [0] used_gshare
);

`include "tournament_branch_predictor_unit_assert.svh"

  localparam int unsigned GW = GSHARE_INDEX_BITS;
  localparam int unsigned BW = BIMODAL_INDEX_BITS;
  localparam int unsigned CW = CHOOSER_INDEX_BITS;
  localparam int unsigned HW = HISTORY_BITS;
  localparam int unsigned CLR_W = (GW > BW) ? ((GW > CW) ? GW : CW)
                                            : ((BW > CW) ? BW : CW);
  localparam int unsigned GSH_DEPTH = 2 ** GW;
  localparam int unsigned BIM_DEPTH = 2 ** BW;
  localparam int unsigned CHO_DEPTH = 2 ** CW;

  // Counter tables.
  ctr_t gsh_mem [GSH_DEPTH];
  ctr_t bim_mem [BIM_DEPTH];
  ctr_t cho_mem [CHO_DEPTH];

  // Clearing pass state.
  logic             clr_busy_r;
  logic [CLR_W-1:0] clr_idx_r;

  // Global history, newest outcome in the top bit.
  logic [HW-1:0] hist_r, hist_nxt;
  logic [GW-1:0] hist_sh;

  // Input side.
  logic          in_fire;
  logic [PC_W-1:0] in_pc;
  logic          in_taken;
  logic [GW-1:0] gi_in;
  logic [BW-1:0] bi_in;
  logic [CW-1:0] ci_in;

  // Second stage: item whose table reads are in flight.
  logic          s1_vld_r;
  logic          s1_taken_r;
  logic [GW-1:0] s1_gi_r;
  logic [BW-1:0] s1_bi_r;
  logic [CW-1:0] s1_ci_r;
  ctr_t          g_rd_r, b_rd_r, c_rd_r;
  logic          s1_adv;

  // Last write into each table, for forwarding.
  logic          g_lw_vld_r, b_lw_vld_r, c_lw_vld_r;
  logic [GW-1:0] g_lw_addr_r;
  logic [BW-1:0] b_lw_addr_r;
  logic [CW-1:0] c_lw_addr_r;
  ctr_t          g_lw_data_r, b_lw_data_r, c_lw_data_r;

  ctr_t g_cur, b_cur, c_cur;
  logic gsh_pred, bim_pred, use_g, pred;
  logic g_upd, b_upd, c_upd;
  ctr_t g_new, b_new, c_new;

  // Table write ports, shared between the clearing pass and training.
  logic          g_we, b_we, c_we;
  logic [GW-1:0] g_waddr;
  logic [BW-1:0] b_waddr;
  logic [CW-1:0] c_waddr;
  ctr_t          g_wdata, b_wdata, c_wdata;

  // Output register.
  logic                   out_vld_r;
  logic                   out_pred_r, out_used_g_r, out_mis_r;

  assign in_pc    = in_tdata[PC_W-1:0];
  assign in_taken = in_tdata[TAKEN_BIT];

  // The history lands on the upper gshare index bits.
  generate
    if (GW >= HW) begin : g_hist_short
      assign hist_sh = GW'(hist_r) << (GW - HW);
    end else begin : g_hist_long
      assign hist_sh = hist_r[HW-1 -: GW];
    end
  endgenerate

  // Word address is pc[23:2]; each table takes its low bits.
  assign gi_in = in_pc[GW+1:2] ^ hist_sh;
  assign bi_in = in_pc[BW+1:2];
  assign ci_in = in_pc[CW+1:2];

  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_vld_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  assign hist_nxt = (hist_r >> 1) | (HW'(in_taken) << (HW - 1));

  // Forward the previous write when it hit the entry this item read.
  always_comb begin
    g_cur = (g_lw_vld_r && g_lw_addr_r == s1_gi_r) ? g_lw_data_r : g_rd_r;
    b_cur = (b_lw_vld_r && b_lw_addr_r == s1_bi_r) ? b_lw_data_r : b_rd_r;
    c_cur = (c_lw_vld_r && c_lw_addr_r == s1_ci_r) ? c_lw_data_r : c_rd_r;

    gsh_pred = g_cur[1];
    bim_pred = b_cur[1];
    use_g    = c_cur[1];
    pred     = use_g ? gsh_pred : bim_pred;

    // Only the selected predictor trains; the chooser moves only on disagreement.
    g_upd = s1_adv && use_g;
    b_upd = s1_adv && !use_g;
    c_upd = s1_adv && (gsh_pred != bim_pred);
    g_new = train_ctr(g_cur, s1_taken_r);
    b_new = train_ctr(b_cur, s1_taken_r);
    c_new = train_ctr(c_cur, gsh_pred == s1_taken_r);
  end

  always_comb begin
    if (clr_busy_r) begin
      g_we    = 1'b1;
      b_we    = 1'b1;
      c_we    = 1'b1;
      g_waddr = clr_idx_r[GW-1:0];
      b_waddr = clr_idx_r[BW-1:0];
      c_waddr = clr_idx_r[CW-1:0];
      g_wdata = CTR_WEAK_TAKEN;
      b_wdata = CTR_WEAK_TAKEN;
      c_wdata = CTR_WEAK_NOT_TKN;
    end else begin
      g_we    = g_upd;
      b_we    = b_upd;
      c_we    = c_upd;
      g_waddr = s1_gi_r;
      b_waddr = s1_bi_r;
      c_waddr = s1_ci_r;
      g_wdata = g_new;
      b_wdata = b_new;
      c_wdata = c_new;
    end
  end

  // Tables: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (g_we) gsh_mem[g_waddr] <= g_wdata;
    if (in_fire) g_rd_r <= gsh_mem[gi_in];
  end

  always_ff @(posedge clk) begin
    if (b_we) bim_mem[b_waddr] <= b_wdata;
    if (in_fire) b_rd_r <= bim_mem[bi_in];
  end

  always_ff @(posedge clk) begin
    if (c_we) cho_mem[c_waddr] <= c_wdata;
    if (in_fire) c_rd_r <= cho_mem[ci_in];
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
      hist_r     <= '0;
      s1_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      g_lw_vld_r <= 1'b0;
      b_lw_vld_r <= 1'b0;
      c_lw_vld_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (&clr_idx_r) clr_busy_r <= 1'b0;
      end
      if (in_fire) begin
        hist_r   <= hist_nxt;
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
      if (g_upd) g_lw_vld_r <= 1'b1;
      if (b_upd) b_lw_vld_r <= 1'b1;
      if (c_upd) c_lw_vld_r <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_taken_r <= in_taken;
      s1_gi_r    <= gi_in;
      s1_bi_r    <= bi_in;
      s1_ci_r    <= ci_in;
    end
    if (g_upd) begin
      g_lw_addr_r <= s1_gi_r;
      g_lw_data_r <= g_new;
    end
    if (b_upd) begin
      b_lw_addr_r <= s1_bi_r;
      b_lw_data_r <= b_new;
    end
    if (c_upd) begin
      c_lw_addr_r <= s1_ci_r;
      c_lw_data_r <= c_new;
    end
    if (s1_adv) begin
      out_pred_r   <= pred;
      out_used_g_r <= use_g;
      out_mis_r    <= pred != s1_taken_r;
    end
  end

  always_comb begin
    out_tdata              = '0;
    out_tdata[PRED_BIT]    = out_pred_r;
    out_tdata[MISPRED_BIT] = out_mis_r;
  end
  assign out_tuser  = out_used_g_r;
  assign out_tvalid = out_vld_r;

  `TBPU_ASSERT(a_no_accept_in_clear, clk, rst_n, clr_busy_r |-> !in_tready)
  `TBPU_ASSERT(a_hist_takes_outcome, clk, rst_n,
               in_fire |=> hist_r[HW-1] == $past(in_tdata[TAKEN_BIT]))
  `TBPU_ASSERT(a_one_predictor_trains, clk, rst_n, !(g_upd && b_upd))
  `TBPU_ASSERT(a_stage_fills_output, clk, rst_n, s1_adv |=> out_tvalid)
  `TBPU_ASSERT(a_clear_blocks_pipe, clk, rst_n, clr_busy_r |-> !s1_vld_r && !out_vld_r)

endmodule
